[src/cmss_pkg.sv]
`default_nettype none
package cmss_pkg;

    typedef logic [3:0][63:0] t_sip_v;

    localparam logic [63:0] SIP_C0     = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1     = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2     = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3     = 64'h7465646279746573;
    localparam logic [63:0] HASH_PRIME = 64'hffffffffffffffc5;

    localparam logic [2:0] CFG_TABLE_ENTRIES = 3'd0;
    localparam logic [2:0] CFG_NUM_HASHES    = 3'd1;
    localparam logic [2:0] CFG_KEY_A_LOW     = 3'd2;
    localparam logic [2:0] CFG_KEY_A_HIGH    = 3'd3;
    localparam logic [2:0] CFG_KEY_B_LOW     = 3'd4;
    localparam logic [2:0] CFG_KEY_B_HIGH    = 3'd5;

    localparam logic REQ_INCREMENT = 1'b0;
    localparam logic REQ_QUERY     = 1'b1;

    // remainder bits resolved per cycle, and division steps per 64-bit hash
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = 64 / DIV_BITS;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_sip_v sip_round(input t_sip_v v);
        t_sip_v w;
        w = v;
        w[0] = w[0] + w[1]; w[1] = rotl(w[1], 13); w[1] = w[1] ^ w[0];
        w[0] = rotl(w[0], 32);
        w[2] = w[2] + w[3]; w[3] = rotl(w[3], 16); w[3] = w[3] ^ w[2];
        w[0] = w[0] + w[3]; w[3] = rotl(w[3], 21); w[3] = w[3] ^ w[0];
        w[2] = w[2] + w[1]; w[1] = rotl(w[1], 17); w[1] = w[1] ^ w[2];
        w[2] = rotl(w[2], 32);
        sip_round = w;
    endfunction

endpackage
`default_nettype wire

[src/cmss_if.sv]
`default_nettype none
interface cmss_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] item_bytes;
    logic [3:0]  item_length;

    modport source (output valid, req_type, item_bytes, item_length, input ready);
    modport sink   (input valid, req_type, item_bytes, item_length, output ready);
endinterface

interface cmss_out_if;
    logic        valid;
    logic        ready;
    logic        overflow;
    logic [31:0] estimate;

    modport source (output valid, overflow, estimate, input ready);
    modport sink   (input valid, overflow, estimate, output ready);
endinterface
`default_nettype wire

[src/count_min_sketch_siphash.sv]
// throughput: one word at a time; the next is taken once the result is registered
// each hash costs one prime reduction, one select, a remainder pass at 4 bits per cycle
//   over the 64-bit hash, then a registered table read and the write back
// reset: after i_rst_n the table is swept to zero, entry by entry, no word taken
`default_nettype none
module count_min_sketch_siphash
    import cmss_pkg::*;
#(
    parameter int TABLE_DEPTH    = 65536,
    parameter int COUNT_WIDTH    = 32,
    parameter int MAX_HASHES     = 16,
    parameter int MAX_ITEM_BYTES = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cmss_in_if.sink    i_req,
    cmss_out_if.source o_res,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [63:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = AW + 1;
    localparam int IW = $clog2(MAX_HASHES) + 1;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_SIP  = 4'd2;
    localparam logic [3:0] ST_PRE  = 4'd3;
    localparam logic [3:0] ST_SEL  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_RD   = 4'd6;
    localparam logic [3:0] ST_WB   = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]  r_state;
    logic [AW-1:0] r_clr;

    logic [16:0] r_cfg_entries;
    logic [4:0]  r_cfg_hashes;
    logic [63:0] r_key_a_lo, r_key_a_hi, r_key_b_lo, r_key_b_hi;

    logic          r_req;
    logic          r_full;
    logic [63:0]   r_item;
    logic [63:0]   r_tail;
    logic [EW-1:0] r_entries;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_i;

    t_sip_v      r_v;
    logic [2:0]  r_step;
    logic        r_hsel;
    logic [63:0] r_h0, r_h1, r_prod, r_pm, r_div;
    logic [EW-1:0] r_rem;
    logic [3:0]  r_cnt;

    logic [COUNT_WIDTH-1:0] r_min;
    logic                   r_ovf;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [COUNT_WIDTH-1:0] r_mem [TABLE_DEPTH];

    logic                   r_out_valid;
    logic                   r_out_ovf;
    logic [31:0]            r_out_est;

    // clamps of the live configuration and the incoming word
    logic [31:0] ent_w, k_w;
    logic [3:0]  len_w;
    logic [63:0] mask_w, tail_w;
    t_sip_v      init_a, init_b, v_in, v_out;
    logic [63:0] fold;
    logic [EW-1:0] rem_next;
    logic [63:0] h_sel;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic        take;
    logic        load_out;

    assign take     = i_req.valid && i_req.ready;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    assign i_req.ready    = (r_state == ST_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.overflow = r_out_ovf;
    assign o_res.estimate = r_out_est;

    always_comb begin
        ent_w = (r_cfg_entries == 17'd0) ? 32'd1 :
                ((32'(r_cfg_entries) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                         : 32'(r_cfg_entries));
        k_w = (r_cfg_hashes == 5'd0) ? 32'd1 :
              ((32'(r_cfg_hashes) > 32'(MAX_HASHES)) ? 32'(MAX_HASHES)
                                                     : 32'(r_cfg_hashes));
        len_w = (i_req.item_length > 4'(MAX_ITEM_BYTES)) ? 4'(MAX_ITEM_BYTES)
                                                         : i_req.item_length;
        for (int j = 0; j < 8; j++) begin
            mask_w[8*j +: 8] = (4'(j) < len_w) ? 8'hff : 8'h00;
        end
        tail_w = {4'd0, len_w, 56'd0};
        if (len_w != 4'd8) begin
            tail_w = tail_w | (i_req.item_bytes & mask_w);
        end
    end

    always_comb begin
        init_a[0] = r_key_a_lo ^ SIP_C0;
        init_a[1] = r_key_a_hi ^ SIP_C1;
        init_a[2] = r_key_a_lo ^ SIP_C2;
        init_a[3] = r_key_a_hi ^ SIP_C3;
        init_b[0] = r_key_b_lo ^ SIP_C0;
        init_b[1] = r_key_b_hi ^ SIP_C1;
        init_b[2] = r_key_b_lo ^ SIP_C2;
        init_b[3] = r_key_b_hi ^ SIP_C3;
        // message injection before the round of steps 0, 2 and 4
        v_in = r_v;
        if (r_step == 3'd0) begin
            v_in[3] = v_in[3] ^ r_item;
        end
        if (r_step == 3'd2) begin
            if (r_full) begin
                v_in[0] = v_in[0] ^ r_item;
            end
            v_in[3] = v_in[3] ^ r_tail;
        end
        if (r_step == 3'd4) begin
            v_in[0] = v_in[0] ^ r_tail;
            v_in[2] = v_in[2] ^ 64'hff;
        end
        v_out = sip_round(v_in);
        fold  = v_out[0] ^ v_out[1] ^ v_out[2] ^ v_out[3];
    end

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb begin
        logic [EW:0] t;
        rem_next = r_rem;
        for (int b = 0; b < DIV_BITS; b++) begin
            t = {rem_next, r_div[63-b]};
            if (t >= {1'b0, r_entries}) begin
                t = t - {1'b0, r_entries};
            end
            rem_next = t[EW-1:0];
        end
    end

    always_comb begin
        if (r_i == IW'(0)) begin
            h_sel = r_h0;
        end else if (r_i == IW'(1)) begin
            h_sel = r_h1;
        end else begin
            h_sel = r_h0 + r_pm;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rem[AW-1:0];
        mem_wdata = r_rdata + COUNT_WIDTH'(1);
        if (r_state == ST_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == ST_WB && r_req == REQ_INCREMENT && r_rdata != '1) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_rem[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_entries <= 17'd65536;
            r_cfg_hashes  <= 5'd4;
            r_key_a_lo    <= '0;
            r_key_a_hi    <= '0;
            r_key_b_lo    <= '0;
            r_key_b_hi    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TABLE_ENTRIES: r_cfg_entries <= i_cfg_data[16:0];
                CFG_NUM_HASHES:    r_cfg_hashes  <= i_cfg_data[4:0];
                CFG_KEY_A_LOW:     r_key_a_lo    <= i_cfg_data;
                CFG_KEY_A_HIGH:    r_key_a_hi    <= i_cfg_data;
                CFG_KEY_B_LOW:     r_key_b_lo    <= i_cfg_data;
                CFG_KEY_B_HIGH:    r_key_b_hi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (take) begin
                        r_state <= ST_SIP;
                    end
                end
                ST_SIP: begin
                    if (r_step == 3'd7 && r_hsel) begin
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE:  r_state <= ST_SEL;
                ST_SEL:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_cnt == 4'(DIV_STEPS - 1)) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD:   r_state <= ST_WB;
                ST_WB: begin
                    r_state <= (r_i == r_k - IW'(1)) ? ST_DONE : ST_PRE;
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req     <= i_req.req_type;
            r_full    <= (len_w == 4'd8);
            r_item    <= i_req.item_bytes;
            r_tail    <= tail_w;
            r_entries <= ent_w[EW-1:0];
            r_k       <= k_w[IW-1:0];
            r_v       <= init_a;
            r_step    <= (len_w == 4'd8) ? 3'd0 : 3'd2;
            r_hsel    <= 1'b0;
        end
        if (r_state == ST_SIP) begin
            r_v    <= v_out;
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                if (!r_hsel) begin
                    r_h0   <= fold;
                    r_v    <= init_b;
                    r_step <= r_full ? 3'd0 : 3'd2;
                    r_hsel <= 1'b1;
                end else begin
                    r_h1   <= fold;
                    r_i    <= '0;
                    r_prod <= '0;
                    r_ovf  <= 1'b0;
                    r_min  <= '0;
                end
            end
        end
        if (r_state == ST_PRE) begin
            r_pm <= (r_prod >= HASH_PRIME) ? r_prod - HASH_PRIME : r_prod;
        end
        if (r_state == ST_SEL) begin
            r_div  <= h_sel;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_prod <= r_prod + r_h1;
        end
        if (r_state == ST_DIV) begin
            r_rem <= rem_next;
            r_div <= r_div << DIV_BITS;
            r_cnt <= r_cnt + 4'd1;
        end
        if (r_state == ST_WB) begin
            r_i <= r_i + IW'(1);
            if (r_req == REQ_INCREMENT) begin
                if (r_rdata == '1) begin
                    r_ovf <= 1'b1;
                end
            end else if (r_i == IW'(0) || r_rdata < r_min) begin
                r_min <= r_rdata;
            end
        end
        if (load_out) begin
            r_out_ovf <= (r_req == REQ_INCREMENT) ? r_ovf : 1'b0;
            r_out_est <= (r_req == REQ_QUERY) ? 32'(r_min) : 32'd0;
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_rem < r_entries))
        else $error("table index not below table size");

    a_hash_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> (r_i < r_k))
        else $error("hash index beyond hash count");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_state == ST_SIP))
        else $error("accepted word did not start hashing");

    a_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_ovf && (r_out_est != 32'd0)))
        else $error("result carries both overflow and estimate");

endmodule
`default_nettype wire
